// ===== hw/rtl/hsvpb_pkg.sv =====
package hsvpb_pkg;

   // Field widths.
   localparam int HUE_W      = 9;
   localparam int CH_W       = 8;
   localparam int DUTY_W     = 8;
   localparam int POS_W      = 5;
   localparam int SECTOR_W   = 4;
   localparam int FRAC_W     = 6;

   // One pixel is 24 bits on the wire, sent green, red, blue, MSB first.
   localparam int BITS_PER_PIXEL = 24;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BITS_PER_PIXEL - 1);

   // Front pipeline length and queue sizing.
   localparam int PIPE_DEPTH  = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int CREDIT_W    = 4;

   // Register map.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_DUTY  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_DUTY = 1'b1;
   localparam logic [DUTY_W-1:0] ONE_DUTY_RESET  = 8'd53;
   localparam logic [DUTY_W-1:0] ZERO_DUTY_RESET = 8'd20;

   // Reciprocals for the two constant divisions, floor(2^24/255) and floor(2^32/15300).
   // Both underestimate, so the quotient is low by at most one and is fixed by one compare.
   localparam logic [16:0] RECIP_255   = 17'd65793;
   localparam logic [18:0] RECIP_15300 = 19'd280716;
   localparam logic [15:0] DIV_P       = 16'd255;
   localparam logic [21:0] DIV_QT      = 22'd15300;

   typedef logic [3*CH_W-1:0] grb_type;

   // One queue word: the packed GRB colors of both strips.
   typedef struct packed {
      grb_type left_grb;
      grb_type right_grb;
   } word_type;

   // Head of the queue as seen by the bit serializer.
   typedef struct packed {
      logic     vld;
      word_type word;
   } head_type;

   // Sector of the color wheel: the number of 60 degree steps at or below the hue.
   function automatic logic [SECTOR_W-1:0] hue_sector(input logic [HUE_W-1:0] hue);
      logic [SECTOR_W-1:0] sec;
      sec = '0;
      for (int k = 1; k <= 8; k++) begin
         if (hue >= HUE_W'(k * 60)) begin
            sec = SECTOR_W'(k);
         end
      end
      return sec;
   endfunction

endpackage

// ===== hw/rtl/hsv_pixel_pair_to_ws2812_bits.sv =====
// Converts one pixel pair (left and right strip, each hue 0..360, saturation and value
// 0..255) to 8-bit RGB by the six-sector method with exact truncating integer division,
// then sends 24 words, one per color bit in G, R, B order, MSB first, each carrying the
// timer duty of that bit for both strips (one_bit_duty at index 0, zero_bit_duty at
// index 1). A pair's words leave one word per cycle while the output is not stalled,
// which is the sustained rate: the bit serializer is the limit. The color pipeline has 6
// register stages, the four-word queue adds one and the serializer two (load and output
// word). A new pair is taken while the previous one is still being sent, so back-to-back
// pairs stream with no gap.
module hsv_pixel_pair_to_ws2812_bits (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [hsvpb_pkg::HUE_W-1:0]     req_left_hue,
   input  logic [hsvpb_pkg::CH_W-1:0]      req_left_saturation,
   input  logic [hsvpb_pkg::CH_W-1:0]      req_left_value,
   input  logic [hsvpb_pkg::HUE_W-1:0]     req_right_hue,
   input  logic [hsvpb_pkg::CH_W-1:0]      req_right_saturation,
   input  logic [hsvpb_pkg::CH_W-1:0]      req_right_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [hsvpb_pkg::DUTY_W-1:0]    rsp_left_duty,
   output logic [hsvpb_pkg::DUTY_W-1:0]    rsp_right_duty,
   output logic [hsvpb_pkg::POS_W-1:0]     rsp_bit_position,
   output logic                            rsp_last_bit,
   input  logic                            csr_write_enable,
   input  logic [hsvpb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hsvpb_pkg::DUTY_W-1:0]    csr_write_data
);
   import hsvpb_pkg::*;

   logic              push, pop;
   word_type          push_word;
   head_type          head;
   logic [QCNT_W-1:0] queue_count;

   hsvpb_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_left_hue         (req_left_hue),
      .req_left_saturation  (req_left_saturation),
      .req_left_value       (req_left_value),
      .req_right_hue        (req_right_hue),
      .req_right_saturation (req_right_saturation),
      .req_right_value      (req_right_value),
      .queue_count          (queue_count),
      .push                 (push),
      .push_word            (push_word)
   );

   hsvpb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head      (head),
      .count     (queue_count)
   );

   hsvpb_serializer u_serializer (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_duty    (rsp_left_duty),
      .rsp_right_duty   (rsp_right_duty),
      .rsp_bit_position (rsp_bit_position),
      .rsp_last_bit     (rsp_last_bit)
   );

endmodule

// ===== hw/rtl/hsvpb_pixel_pipe.sv =====
module hsvpb_pixel_pipe (
   input  logic                        clock,
   input  logic [hsvpb_pkg::HUE_W-1:0] hue,
   input  logic [hsvpb_pkg::CH_W-1:0]  saturation,
   input  logic [hsvpb_pkg::CH_W-1:0]  value,
   output hsvpb_pkg::grb_type          grb
);
   import hsvpb_pkg::*;

   // Stage A: captured inputs.
   logic [HUE_W-1:0]    hue_a_ff;
   logic [CH_W-1:0]     sat_a_ff, val_a_ff;
   // Stage B: sector and offset into the sector.
   logic [SECTOR_W-1:0] sector_b_ff, sector_b_in;
   logic [FRAC_W-1:0]   frac_b_ff, frac_b_in;
   logic [CH_W-1:0]     sat_b_ff, val_b_ff;
   logic [HUE_W-1:0]    base_b;
   // Stage C: saturation scaled by the offset and by its complement.
   logic [13:0]         sf_c_ff, sg_c_ff;
   logic [SECTOR_W-1:0] sector_c_ff;
   logic [CH_W-1:0]     sat_c_ff, val_c_ff;
   // Stage D: numerators of p, q and t.
   logic [15:0]         xp_d_ff;
   logic [21:0]         xq_d_ff, xt_d_ff;
   logic [SECTOR_W-1:0] sector_d_ff;
   logic [CH_W-1:0]     val_d_ff;
   logic                grey_d_ff;
   // Stage E: estimated quotients.
   logic [32:0]         prod_p;
   logic [40:0]         prod_q, prod_t;
   logic [8:0]          qp_e_ff, qq_e_ff, qt_e_ff;
   logic [15:0]         xp_e_ff;
   logic [21:0]         xq_e_ff, xt_e_ff;
   logic [SECTOR_W-1:0] sector_e_ff;
   logic [CH_W-1:0]     val_e_ff;
   logic                grey_e_ff;
   // Stage F: corrected quotients and the chosen color.
   logic [15:0]         rem_p;
   logic [21:0]         rem_q, rem_t;
   logic [CH_W-1:0]     p_val, q_val, t_val;
   logic [CH_W-1:0]     red, green, blue;
   grb_type             grb_ff, grb_in;

   // Sector and offset.
   always_comb begin
      sector_b_in = hue_sector(hue_a_ff);
      base_b      = {5'd0, sector_b_in} * 9'd60;
      frac_b_in   = FRAC_W'(hue_a_ff - base_b);
   end

   // Quotient estimates by reciprocal multiplication.
   always_comb begin
      prod_p = 33'(xp_d_ff) * 33'(RECIP_255);
      prod_q = 41'(xq_d_ff) * 41'(RECIP_15300);
      prod_t = 41'(xt_d_ff) * 41'(RECIP_15300);
   end

   // Quotient correction and sector selection.
   always_comb begin
      rem_p = xp_e_ff - 16'(qp_e_ff) * DIV_P;
      rem_q = xq_e_ff - 22'(qq_e_ff) * DIV_QT;
      rem_t = xt_e_ff - 22'(qt_e_ff) * DIV_QT;
      p_val = (rem_p >= DIV_P)  ? CH_W'(qp_e_ff + 9'd1) : CH_W'(qp_e_ff);
      q_val = (rem_q >= DIV_QT) ? CH_W'(qq_e_ff + 9'd1) : CH_W'(qq_e_ff);
      t_val = (rem_t >= DIV_QT) ? CH_W'(qt_e_ff + 9'd1) : CH_W'(qt_e_ff);
      case (sector_e_ff)
         4'd0: begin
            red = val_e_ff; green = t_val;    blue = p_val;
         end
         4'd1: begin
            red = q_val;    green = val_e_ff; blue = p_val;
         end
         4'd2: begin
            red = p_val;    green = val_e_ff; blue = t_val;
         end
         4'd3: begin
            red = p_val;    green = q_val;    blue = val_e_ff;
         end
         4'd4: begin
            red = t_val;    green = p_val;    blue = val_e_ff;
         end
         default: begin
            red = val_e_ff; green = p_val;    blue = q_val;
         end
      endcase
      // A grey pixel has all three channels at the value.
      if (grey_e_ff) begin
         grb_in = {val_e_ff, val_e_ff, val_e_ff};
      end else begin
         grb_in = {green, red, blue};
      end
   end

   // Pipeline registers; they advance every cycle.
   always_ff @(posedge clock) begin
      hue_a_ff    <= hue;
      sat_a_ff    <= saturation;
      val_a_ff    <= value;

      sector_b_ff <= sector_b_in;
      frac_b_ff   <= frac_b_in;
      sat_b_ff    <= sat_a_ff;
      val_b_ff    <= val_a_ff;

      sf_c_ff     <= 14'(sat_b_ff) * 14'(frac_b_ff);
      sg_c_ff     <= 14'(sat_b_ff) * 14'(6'd60 - frac_b_ff);
      sector_c_ff <= sector_b_ff;
      sat_c_ff    <= sat_b_ff;
      val_c_ff    <= val_b_ff;

      xp_d_ff     <= 16'(val_c_ff) * 16'(8'd255 - sat_c_ff);
      xq_d_ff     <= 22'(val_c_ff) * 22'(14'd15300 - sf_c_ff);
      xt_d_ff     <= 22'(val_c_ff) * 22'(14'd15300 - sg_c_ff);
      sector_d_ff <= sector_c_ff;
      val_d_ff    <= val_c_ff;
      grey_d_ff   <= (sat_c_ff == '0);

      qp_e_ff     <= prod_p[32:24];
      qq_e_ff     <= prod_q[40:32];
      qt_e_ff     <= prod_t[40:32];
      xp_e_ff     <= xp_d_ff;
      xq_e_ff     <= xq_d_ff;
      xt_e_ff     <= xt_d_ff;
      sector_e_ff <= sector_d_ff;
      val_e_ff    <= val_d_ff;
      grey_e_ff   <= grey_d_ff;

      grb_ff      <= grb_in;
   end

   assign grb = grb_ff;

endmodule

// ===== hw/rtl/hsvpb_front.sv =====
module hsvpb_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [hsvpb_pkg::HUE_W-1:0]  req_left_hue,
   input  logic [hsvpb_pkg::CH_W-1:0]   req_left_saturation,
   input  logic [hsvpb_pkg::CH_W-1:0]   req_left_value,
   input  logic [hsvpb_pkg::HUE_W-1:0]  req_right_hue,
   input  logic [hsvpb_pkg::CH_W-1:0]   req_right_saturation,
   input  logic [hsvpb_pkg::CH_W-1:0]   req_right_value,
   input  logic [hsvpb_pkg::QCNT_W-1:0] queue_count,
   output logic                         push,
   output hsvpb_pkg::word_type          push_word
);
   import hsvpb_pkg::*;

   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic [CREDIT_W-1:0]   in_flight;
   logic                  accept;

   // A word is taken only when the queue has room for it and for every word in flight.
   always_comb begin
      in_flight = '0;
      for (int i = 0; i < PIPE_DEPTH; i++) begin
         in_flight = in_flight + CREDIT_W'(vld_ff[i]);
      end
      req_ready = (CREDIT_W'(queue_count) + in_flight) < CREDIT_W'(QUEUE_DEPTH);
      accept    = req_valid && req_ready;
      vld_in    = {vld_ff[PIPE_DEPTH-2:0], accept};
   end

   // Valid bits travel alongside the color pipelines.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   hsvpb_pixel_pipe u_left (
      .clock      (clock),
      .hue        (req_left_hue),
      .saturation (req_left_saturation),
      .value      (req_left_value),
      .grb        (push_word.left_grb)
   );

   hsvpb_pixel_pipe u_right (
      .clock      (clock),
      .hue        (req_right_hue),
      .saturation (req_right_saturation),
      .value      (req_right_value),
      .grb        (push_word.right_grb)
   );

   assign push = vld_ff[PIPE_DEPTH-1];

endmodule

// ===== hw/rtl/hsvpb_queue.sv =====
module hsvpb_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  hsvpb_pkg::word_type          push_word,
   input  logic                         pop,
   output hsvpb_pkg::head_type          head,
   output logic [hsvpb_pkg::QCNT_W-1:0] count
);
   import hsvpb_pkg::*;

   word_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head.vld  = (count_ff != '0);
   assign head.word = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QCNT_W'(QUEUE_DEPTH)))
      else $error("word pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("word popped from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count out of range");
`endif

endmodule

// ===== hw/rtl/hsvpb_serializer.sv =====
module hsvpb_serializer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [hsvpb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hsvpb_pkg::DUTY_W-1:0]    csr_write_data,
   input  hsvpb_pkg::head_type             head,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [hsvpb_pkg::DUTY_W-1:0]    rsp_left_duty,
   output logic [hsvpb_pkg::DUTY_W-1:0]    rsp_right_duty,
   output logic [hsvpb_pkg::POS_W-1:0]     rsp_bit_position,
   output logic                            rsp_last_bit
);
   import hsvpb_pkg::*;

   logic [DUTY_W-1:0] one_duty_ff, zero_duty_ff;
   logic              busy_ff, busy_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   grb_type           left_sr_ff, left_sr_in;
   grb_type           right_sr_ff, right_sr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0] left_duty_ff, right_duty_ff;
   logic [POS_W-1:0]  position_ff;
   logic              last_ff;
   logic              out_free, emit, at_end;

   // Duty registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         one_duty_ff  <= ONE_DUTY_RESET;
         zero_duty_ff <= ZERO_DUTY_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ONE_DUTY:  one_duty_ff  <= csr_write_data;
            CSR_ZERO_DUTY: zero_duty_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // A new word loads as the last bit of the previous one leaves.
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      emit         = out_free && busy_ff;
      at_end       = (pos_ff == LAST_POS);
      pop          = head.vld && (!busy_ff || (emit && at_end));
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      left_sr_in   = left_sr_ff;
      right_sr_in  = right_sr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
         pos_in       = pos_ff + 1'b1;
         left_sr_in   = {left_sr_ff[3*CH_W-2:0], 1'b0};
         right_sr_in  = {right_sr_ff[3*CH_W-2:0], 1'b0};
         if (at_end) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         busy_in     = 1'b1;
         pos_in      = '0;
         left_sr_in  = head.word.left_grb;
         right_sr_in = head.word.right_grb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Shift registers and the output register.
   always_ff @(posedge clock) begin
      left_sr_ff  <= left_sr_in;
      right_sr_ff <= right_sr_in;
      if (emit) begin
         left_duty_ff  <= left_sr_ff[3*CH_W-1]  ? one_duty_ff : zero_duty_ff;
         right_duty_ff <= right_sr_ff[3*CH_W-1] ? one_duty_ff : zero_duty_ff;
         position_ff   <= pos_ff;
         last_ff       <= at_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_duty    = left_duty_ff;
   assign rsp_right_duty   = right_duty_ff;
   assign rsp_bit_position = position_ff;
   assign rsp_last_bit     = last_ff;

`ifndef SYNTH
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff <= LAST_POS))
      else $error("bit counter beyond the last bit");
   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (last_ff == (position_ff == LAST_POS)))
      else $error("last bit flag disagrees with bit position");
   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      (pop && busy_ff) |-> (emit && at_end))
      else $error("word loaded over a word still being sent");
`endif

endmodule

// ===== tb/hsv_pixel_pair_to_ws2812_bits_tb.sv =====
module hsv_pixel_pair_to_ws2812_bits_tb;
   import hsvpb_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 12;
   localparam int MAX_IDLE_BURST = 14;
   localparam int LONG_HOLD      = 300;
   localparam int CSR_SETTLE     = 16;
   localparam int DRAIN_CYCLES   = 40;
   localparam int QUIET_LIMIT    = 3000;
   localparam int MAX_REPORTS    = 10;

   // One pixel pair as it is offered on the input side.
   typedef struct packed {
      logic [HUE_W-1:0] left_hue;
      logic [CH_W-1:0]  left_sat;
      logic [CH_W-1:0]  left_val;
      logic [HUE_W-1:0] right_hue;
      logic [CH_W-1:0]  right_sat;
      logic [CH_W-1:0]  right_val;
   } pixel_pair_type;

   // One duty word as it leaves the block.
   typedef struct packed {
      logic [DUTY_W-1:0] left_duty;
      logic [DUTY_W-1:0] right_duty;
      logic [POS_W-1:0]  bit_position;
      logic              last_bit;
   } duty_word_type;

   // Tracks the duty registers, turns each accepted pair into its 24 duty words
   // and compares the words leaving the block against them in order.
   class duty_scoreboard;
      logic [DUTY_W-1:0] one_duty;
      logic [DUTY_W-1:0] zero_duty;
      duty_word_type     pending_words[$];
      int unsigned       errors;

      function new();
         one_duty  = ONE_DUTY_RESET;
         zero_duty = ZERO_DUTY_RESET;
         errors    = 0;
      endfunction

      function void set_duty(logic [CSR_IDX_W-1:0] idx, logic [DUTY_W-1:0] data);
         if (idx == CSR_ONE_DUTY) begin
            one_duty = data;
         end else if (idx == CSR_ZERO_DUTY) begin
            zero_duty = data;
         end
      endfunction

      // Six-sector HSV to RGB with truncating integer division, packed as G, R, B.
      function grb_type hsv_to_grb(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                                   logic [CH_W-1:0] val);
         int unsigned h, s, v, wheel_step, frac, p, q, t, r, g, b;
         h = hue;
         s = sat;
         v = val;
         if (s == 0) begin
            r = v;
            g = v;
            b = v;
         end else begin
            wheel_step = h / 60;
            frac       = h % 60;
            p = v * (255 - s) / 255;
            q = v * (15300 - s * frac) / 15300;
            t = v * (15300 - s * (60 - frac)) / 15300;
            // Hue of 360 and above falls into the last case.
            case (wheel_step)
               0: begin r = v; g = t; b = p; end
               1: begin r = q; g = v; b = p; end
               2: begin r = p; g = v; b = t; end
               3: begin r = p; g = q; b = v; end
               4: begin r = t; g = p; b = v; end
               default: begin r = v; g = p; b = q; end
            endcase
         end
         return {CH_W'(g), CH_W'(r), CH_W'(b)};
      endfunction

      function void note_pair(pixel_pair_type pair);
         grb_type       left_grb;
         grb_type       right_grb;
         duty_word_type word;
         int            shift;
         left_grb  = hsv_to_grb(pair.left_hue, pair.left_sat, pair.left_val);
         right_grb = hsv_to_grb(pair.right_hue, pair.right_sat, pair.right_val);
         for (int k = 0; k < BITS_PER_PIXEL; k++) begin
            shift             = BITS_PER_PIXEL - 1 - k;
            word.left_duty    = left_grb[shift] ? one_duty : zero_duty;
            word.right_duty   = right_grb[shift] ? one_duty : zero_duty;
            word.bit_position = POS_W'(k);
            word.last_bit     = (k == BITS_PER_PIXEL - 1);
            pending_words.push_back(word);
         end
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= MAX_REPORTS) begin
            $display("%s", msg);
         end
      endfunction

      function void check_word(duty_word_type got);
         duty_word_type want;
         if (pending_words.size() == 0) begin
            report($sformatf("unexpected word: left %0d right %0d pos %0d last %0b",
                             got.left_duty, got.right_duty, got.bit_position,
                             got.last_bit));
            return;
         end
         want = pending_words.pop_front();
         if (got.left_duty !== want.left_duty || got.right_duty !== want.right_duty ||
             got.bit_position !== want.bit_position || got.last_bit !== want.last_bit) begin
            report($sformatf({"word mismatch: expected left %0d right %0d pos %0d last %0b,",
                              " got left %0d right %0d pos %0d last %0b"},
                             want.left_duty, want.right_duty, want.bit_position,
                             want.last_bit, got.left_duty, got.right_duty,
                             got.bit_position, got.last_bit));
         end
      endfunction

      function int unsigned pending();
         return pending_words.size();
      endfunction

      function bit failed();
         return errors != 0;
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [HUE_W-1:0]     req_left_hue = '0;
   logic [CH_W-1:0]      req_left_saturation = '0;
   logic [CH_W-1:0]      req_left_value = '0;
   logic [HUE_W-1:0]     req_right_hue = '0;
   logic [CH_W-1:0]      req_right_saturation = '0;
   logic [CH_W-1:0]      req_right_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [DUTY_W-1:0]    rsp_left_duty;
   logic [DUTY_W-1:0]    rsp_right_duty;
   logic [POS_W-1:0]     rsp_bit_position;
   logic                 rsp_last_bit;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DUTY_W-1:0]    csr_write_data = '0;

   duty_scoreboard board = new();
   bit             sender_idling = 1'b1;
   bit             sink_idling = 1'b1;
   bit             long_hold_req = 1'b0;

   hsv_pixel_pair_to_ws2812_bits u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_left_hue         (req_left_hue),
      .req_left_saturation  (req_left_saturation),
      .req_left_value       (req_left_value),
      .req_right_hue        (req_right_hue),
      .req_right_saturation (req_right_saturation),
      .req_right_value      (req_right_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_left_duty        (rsp_left_duty),
      .rsp_right_duty       (rsp_right_duty),
      .rsp_bit_position     (rsp_bit_position),
      .rsp_last_bit         (rsp_last_bit),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   // Free-running clock.
   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   // Record accepted pairs and check accepted words at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_pair({req_left_hue, req_left_saturation, req_left_value,
                             req_right_hue, req_right_saturation, req_right_value});
         end
         if (rsp_valid && rsp_ready) begin
            board.check_word({rsp_left_duty, rsp_right_duty, rsp_bit_position,
                              rsp_last_bit});
         end
      end
   end

   // Result sink: random stall bursts, plus one long hold when requested.
   initial begin : result_sink
      int unsigned stall;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (sink_idling && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            stall = $urandom_range(1, MAX_IDLE_BURST);
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAILURE");
      $finish;
   end

   function automatic pixel_pair_type make_pair(int lh, int ls, int lv, int rh, int rs,
                                                int rv);
      pixel_pair_type pair;
      pair.left_hue  = HUE_W'(lh);
      pair.left_sat  = CH_W'(ls);
      pair.left_val  = CH_W'(lv);
      pair.right_hue = HUE_W'(rh);
      pair.right_sat = CH_W'(rs);
      pair.right_val = CH_W'(rv);
      return pair;
   endfunction

   // Channel values lean toward the extremes now and then.
   function automatic int random_channel();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // Hue mostly in the color wheel, sometimes past 360 up to the field limit.
   function automatic int random_hue();
      if ($urandom_range(0, 15) == 0) begin
         return $urandom_range(361, (1 << HUE_W) - 1);
      end
      return $urandom_range(0, 360);
   endfunction

   function automatic pixel_pair_type random_pair();
      return make_pair(random_hue(), random_channel(), random_channel(),
                       random_hue(), random_channel(), random_channel());
   endfunction

   // Offer one pair and wait for it to be taken; valid stays high on return.
   task automatic offer_pair(pixel_pair_type pair);
      req_valid            <= 1'b1;
      req_left_hue         <= pair.left_hue;
      req_left_saturation  <= pair.left_sat;
      req_left_value       <= pair.left_val;
      req_right_hue        <= pair.right_hue;
      req_right_saturation <= pair.right_sat;
      req_right_value      <= pair.right_val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Send a list of pairs, with random sender gaps when idling is on.
   task automatic send_pairs(pixel_pair_type pairs[$]);
      int unsigned gap;
      foreach (pairs[i]) begin
         offer_pair(pairs[i]);
         if (sender_idling && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, MAX_IDLE_BURST);
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random(int count);
      pixel_pair_type pairs[$];
      repeat (count) pairs.push_back(random_pair());
      send_pairs(pairs);
   endtask

   // Write both duty registers once every word in flight has come out.
   task automatic write_duties(logic [DUTY_W-1:0] one_val, logic [DUTY_W-1:0] zero_val);
      while (board.pending() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ONE_DUTY;
      csr_write_data   <= one_val;
      board.set_duty(CSR_ONE_DUTY, one_val);
      @(posedge clock);
      csr_index        <= CSR_ZERO_DUTY;
      csr_write_data   <= zero_val;
      board.set_duty(CSR_ZERO_DUTY, zero_val);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Main sequence.
   initial begin : main_sequence
      pixel_pair_type directed[$];

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extremes, every sector boundary, grey, and hues at and past 360.
      directed.push_back(make_pair(0, 0, 0, 511, 255, 255));
      directed.push_back(make_pair(360, 255, 255, 0, 255, 255));
      directed.push_back(make_pair(200, 0, 255, 360, 0, 131));
      directed.push_back(make_pair(59, 255, 255, 60, 255, 255));
      directed.push_back(make_pair(119, 255, 255, 120, 255, 255));
      directed.push_back(make_pair(179, 255, 255, 180, 255, 255));
      directed.push_back(make_pair(239, 255, 255, 240, 255, 255));
      directed.push_back(make_pair(299, 255, 255, 300, 255, 255));
      directed.push_back(make_pair(359, 255, 255, 361, 200, 255));
      directed.push_back(make_pair(420, 128, 200, 480, 77, 250));
      directed.push_back(make_pair(30, 128, 200, 90, 1, 254));
      directed.push_back(make_pair(150, 170, 85, 210, 254, 1));
      directed.push_back(make_pair(270, 85, 170, 330, 255, 0));
      directed.push_back(make_pair(256, 127, 128, 255, 128, 127));
      directed.push_back(make_pair(511, 0, 0, 0, 255, 255));
      send_pairs(directed);
      send_random(25);

      // Extremes of the duty registers.
      write_duties(8'd255, 8'd0);
      send_random(25);

      // Swapped extremes, with a long sink hold so the input backs up.
      write_duties(8'd0, 8'd255);
      long_hold_req = 1'b1;
      send_random(25);

      write_duties(DUTY_W'($urandom_range(0, 255)), DUTY_W'($urandom_range(0, 255)));
      sender_idling = 1'b0;
      sink_idling   = 1'b0;
      send_random(20);
      sender_idling = 1'b1;
      sink_idling   = 1'b1;
      send_random(20);

      // Back to the reset values, then a last stretch with no idling at all.
      write_duties(ONE_DUTY_RESET, ZERO_DUTY_RESET);
      send_random(10);
      sender_idling = 1'b0;
      sink_idling   = 1'b0;
      send_random(25);

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failed()) begin
         $display("FAILURE");
      end else begin
         $display("SUCCESS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/hsvpb_pkg.sv
hw/rtl/hsvpb_pixel_pipe.sv
hw/rtl/hsvpb_front.sv
hw/rtl/hsvpb_queue.sv
hw/rtl/hsvpb_serializer.sv
hw/rtl/hsv_pixel_pair_to_ws2812_bits.sv
tb/hsv_pixel_pair_to_ws2812_bits_tb.sv
